// ----- src/bfa_pkg.sv -----
package bfa_pkg;

  // bitmap word geometry
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam logic [WORD_W-1:0] FULL_WORD = '1;

  // result field widths
  localparam int unsigned ADDR_W  = 27;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PHYS_W  = 32;

  // request codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RMW_RD,
    ST_RMW_WR
  } state_e;

  // request beat
  typedef struct packed {
    cmd_e              cmd;
    logic [PHYS_W-1:0] phys_address;
  } req_t;

  // result beat
  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic              done_res;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  total_count;
  } res_t;

endpackage

// ----- src/bfa_ram.sv -----
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/bitmap_frame_allocator_top.sv -----
// Bitmap page frame allocator: one used/free bit per frame, held in 32-bit words in a
// single-port-write, registered-read RAM. After reset a clearing pass writes every word
// to all ones (every frame used), with busy high throughout. A request is taken when
// start is high and busy is low. Free, release and reserve are a read-modify-write of
// one word: read in ST_RMW_RD, updated in ST_RMW_WR, the result strobe registered from
// there. Allocate reads the bitmap one word per cycle from word 0 until a word with a
// clear bit turns up and claims that bit in ST_MARK; a full bitmap gives the strobe once
// the last word has been checked. With a zero free counter it answers as fast as a free.
// Each result appears for exactly one cycle on done_o and must be taken then; the next
// request can be given in that same cycle.
module bitmap_frame_allocator_top #(
  parameter int unsigned FRAME_COUNT = 32768,
  parameter int unsigned PAGE_SHIFT  = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bfa_pkg::req_t req_i,
  output logic          done_o,
  output bfa_pkg::res_t res_o
);

  import bfa_pkg::*;

  localparam int unsigned WordCount = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int unsigned AddrW     = $clog2(WordCount);
  localparam logic [AddrW-1:0] LastWord = AddrW'(WordCount - 1);
  localparam logic [CNT_W-1:0] CntLimit =
    CNT_W'((FRAME_COUNT < 65535) ? FRAME_COUNT : 65535);

  // lowest clear bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  state_e             state_q, state_d;
  logic [AddrW-1:0]   ptr_q, ptr_d;
  logic [AddrW-1:0]   chk_ptr_q, chk_ptr_d;
  logic               chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]   word_q, word_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [WORD_W-1:0]  data_q, data_d;
  cmd_e               cmd_q, cmd_d;
  logic               in_range_q, in_range_d;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]   total_cnt_q, total_cnt_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [PHYS_W-1:0]  req_frame;
  logic [WORD_W-1:0]  bit_mask;
  logic               bit_used;
  logic [AddrW+BIT_W-1:0] alloc_frame;
  logic [63:0]        alloc_addr;

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WordCount)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request decode and word arithmetic
  assign req_frame   = req_i.phys_address >> PAGE_SHIFT;
  assign bit_mask    = WORD_W'(1) << bit_q;
  assign bit_used    = ram_rdata[bit_q];
  assign alloc_frame = {word_q, bit_q};
  assign alloc_addr  = 64'(alloc_frame) << PAGE_SHIFT;

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      free_cnt_q  <= '0;
      total_cnt_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      chk_vld_q   <= chk_vld_d;
      free_cnt_q  <= free_cnt_d;
      total_cnt_q <= total_cnt_d;
      done_q      <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_ptr_q  <= chk_ptr_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
    data_q     <= data_d;
    cmd_q      <= cmd_d;
    in_range_q <= in_range_d;
    res_q      <= res_d;
  end

  // next state, bitmap access and result
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    chk_ptr_d   = chk_ptr_q;
    chk_vld_d   = 1'b0;
    word_d      = word_q;
    bit_d       = bit_q;
    data_d      = data_q;
    cmd_d       = cmd_q;
    in_range_d  = in_range_q;
    free_cnt_d  = free_cnt_q;
    total_cnt_d = total_cnt_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = FULL_WORD;
    ram_raddr   = word_q;

    unique case (state_q)
      // clearing pass: every word to all ones
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = FULL_WORD;
        if (ptr_q == LastWord) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_d      = req_i.cmd;
          in_range_d = (req_frame < PHYS_W'(FRAME_COUNT));
          word_d     = req_frame[BIT_W +: AddrW];
          bit_d      = req_frame[BIT_W-1:0];
          ptr_d      = '0;
          if (req_i.cmd == CMD_ALLOC && free_cnt_q != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RMW_RD;
          end
        end
      end

      // one word read per cycle, each checked in the cycle after its read
      ST_SCAN: begin
        ram_raddr = ptr_q;
        chk_vld_d = 1'b1;
        chk_ptr_d = ptr_q;
        ptr_d     = (ptr_q == LastWord) ? '0 : ptr_q + AddrW'(1);
        if (chk_vld_q) begin
          if (ram_rdata != FULL_WORD) begin
            word_d    = chk_ptr_q;
            data_d    = ram_rdata;
            bit_d     = lowest_zero(ram_rdata);
            chk_vld_d = 1'b0;
            state_d   = ST_MARK;
          end else if (chk_ptr_q == LastWord) begin
            res_d     = '{frame_address: '0, done_res: 1'b0,
                          free_count: free_cnt_q, total_count: total_cnt_q};
            done_d    = 1'b1;
            chk_vld_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end

      // claim the found frame
      ST_MARK: begin
        ram_we     = 1'b1;
        ram_wdata  = data_q | bit_mask;
        free_cnt_d = (free_cnt_q != '0) ? free_cnt_q - CNT_W'(1) : '0;
        res_d      = '{frame_address: alloc_addr[ADDR_W-1:0], done_res: 1'b1,
                       free_count: free_cnt_d, total_count: total_cnt_q};
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end

      ST_RMW_RD: begin
        state_d = ST_RMW_WR;
      end

      // update one frame bit and the counters
      ST_RMW_WR: begin
        res_d = '{frame_address: '0, done_res: 1'b0,
                  free_count: '0, total_count: '0};
        if (in_range_q) begin
          case (cmd_q)
            CMD_FREE: begin
              if (bit_used) begin
                ram_we         = 1'b1;
                ram_wdata      = ram_rdata & ~bit_mask;
                free_cnt_d     = (free_cnt_q < CntLimit) ? free_cnt_q + CNT_W'(1)
                                                         : CntLimit;
                res_d.done_res = 1'b1;
              end
            end
            CMD_RELEASE: begin
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata & ~bit_mask;
              free_cnt_d     = (free_cnt_q < CntLimit) ? free_cnt_q + CNT_W'(1)
                                                       : CntLimit;
              total_cnt_d    = (total_cnt_q < CntLimit) ? total_cnt_q + CNT_W'(1)
                                                        : CntLimit;
              res_d.done_res = 1'b1;
            end
            CMD_RESERVE: begin
              if (!bit_used) begin
                ram_we         = 1'b1;
                ram_wdata      = ram_rdata | bit_mask;
                free_cnt_d     = (free_cnt_q != '0) ? free_cnt_q - CNT_W'(1) : '0;
                res_d.done_res = 1'b1;
              end
            end
            default: begin
              // allocate with nothing counted free is refused
            end
          endcase
        end
        res_d.free_count  = free_cnt_d;
        res_d.total_count = total_cnt_d;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- src/bfa_checker.sv -----
module bfa_checker #(
  parameter int unsigned FRAME_COUNT = 32768
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input bfa_pkg::req_t req_i,
  input logic          done_o,
  input bfa_pkg::res_t res_o
);

  import bfa_pkg::*;

  localparam logic [CNT_W-1:0] CntLimit =
    CNT_W'((FRAME_COUNT < 65535) ? FRAME_COUNT : 65535);

  logic accept;
  assign accept = start && !busy;

  // a result beat only shows once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // every accepted request makes the block busy in the cycle after, with no result beat yet
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("request not held busy");

  // result strobes never come back to back
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a non-zero frame address only comes with a successful result
  a_addr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.frame_address != '0) |-> res_o.done_res)
    else $error("frame address without success");

  // counters stay within their saturation limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.free_count <= CntLimit) && (res_o.total_count <= CntLimit))
    else $error("counter beyond limit");

endmodule

bind bitmap_frame_allocator_top bfa_checker #(
  .FRAME_COUNT (FRAME_COUNT)
) u_bfa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .res_o  (res_o)
);

// ----- verif/tb_bitmap_frame_allocator_top.sv -----
`timescale 1ns / 100ps

module tb_bitmap_frame_allocator_top;
  import bfa_pkg::*;

  localparam int unsigned FRAMES       = 32768;
  localparam int unsigned PG_SHIFT     = 12;
  localparam int unsigned MAP_WORDS    = (FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned CNT_TOP      = (FRAMES < 65535) ? FRAMES : 65535;
  localparam int unsigned RAND_ITEMS   = 580;
  localparam int unsigned RAND_PHASES  = 5;
  localparam res_t        NO_RES       = '0;

  // one row of the directed table
  typedef struct {
    cmd_e        cmd;
    logic [31:0] addr;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t res;

  // shadow of the allocator state
  logic [WORD_W-1:0] frame_map [MAP_WORDS];
  int unsigned       shadow_free;
  int unsigned       shadow_total;

  res_t        awaited_res [$];
  dir_row_t    dir_tab [$];
  int unsigned errors    = 0;
  int unsigned send_idle = 0;

  bitmap_frame_allocator_top #(
    .FRAME_COUNT(FRAMES),
    .PAGE_SHIFT (PG_SHIFT)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .res_o (res)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run guard
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // apply one request to the shadow bitmap and return the result beat it gives
  function automatic res_t apply_request(input req_t r);
    res_t        beat;
    logic [31:0] frame;
    bit          in_rng;
    bit          found;
    beat   = '0;
    found  = 1'b0;
    frame  = r.phys_address >> PG_SHIFT;
    in_rng = frame < FRAMES;
    case (r.cmd)
      CMD_ALLOC: begin
        // lowest clear bit, full words skipped, only with a nonzero free count
        if (shadow_free != 0) begin
          for (int w = 0; w < MAP_WORDS && !found; w++) begin
            if (frame_map[w] != FULL_WORD) begin
              for (int b = 0; b < WORD_W && !found; b++) begin
                if (w * WORD_W + b < FRAMES && !frame_map[w][b]) begin
                  frame_map[w][b]    = 1'b1;
                  shadow_free        = shadow_free - 1;
                  beat.frame_address = ADDR_W'((w * WORD_W + b) << PG_SHIFT);
                  beat.done_res      = 1'b1;
                  found              = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_FREE: begin
        // double-free guard
        if (in_rng && frame_map[frame / WORD_W][frame % WORD_W]) begin
          frame_map[frame / WORD_W][frame % WORD_W] = 1'b0;
          if (shadow_free < CNT_TOP) shadow_free++;
          beat.done_res = 1'b1;
        end
      end
      CMD_RELEASE: begin
        // counted even when the frame is already free
        if (in_rng) begin
          frame_map[frame / WORD_W][frame % WORD_W] = 1'b0;
          if (shadow_free < CNT_TOP) shadow_free++;
          if (shadow_total < CNT_TOP) shadow_total++;
          beat.done_res = 1'b1;
        end
      end
      default: begin
        if (in_rng && !frame_map[frame / WORD_W][frame % WORD_W]) begin
          frame_map[frame / WORD_W][frame % WORD_W] = 1'b1;
          if (shadow_free != 0) shadow_free--;
          beat.done_res = 1'b1;
        end
      end
    endcase
    beat.free_count  = CNT_W'(shadow_free);
    beat.total_count = CNT_W'(shadow_total);
    return beat;
  endfunction

  // mostly low frames so allocations hit early, some far up and some out of range
  function automatic logic [31:0] pick_address();
    int unsigned sel;
    logic [31:0] frame;
    sel = $urandom_range(99);
    if (sel < 70) frame = $urandom_range(63);
    else if (sel < 82) frame = $urandom_range(1023, 64);
    else if (sel < 90) frame = $urandom_range(FRAMES - 1, FRAMES - 64);
    else if (sel < 94) frame = $urandom_range(FRAMES - 65, 1024);
    else return $urandom_range(32'hFFFF_FFFF, FRAMES << PG_SHIFT);
    return (frame << PG_SHIFT) | $urandom_range(4095);
  endfunction

  // offer one request beat, with any random idle cycles first, and log its expected result
  task automatic issue(input req_t r, input bit typed, input res_t want);
    res_t pred;
    pred = apply_request(r);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    awaited_res.push_back(typed ? want : pred);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && done !== 1'b0) begin
      if (awaited_res.size() == 0 || done !== 1'b1) begin
        errors++;
        $display("%0t: strobe %b expected no beat, got %h", $time, done, res);
      end else begin
        want = awaited_res.pop_front();
        flag_field("frame_address", 32'(want.frame_address), 32'(res.frame_address));
        flag_field("done_res", 32'(want.done_res), 32'(res.done_res));
        flag_field("free_count", 32'(want.free_count), 32'(res.free_count));
        flag_field("total_count", 32'(want.total_count), 32'(res.total_count));
      end
    end
  end

  initial begin : stimulus
    req_t        r;
    int unsigned sel;

    // shadow state after reset: every frame used
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = FULL_WORD;
    shadow_free  = 0;
    shadow_total = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: refusals, frame zero, top frame, double release, empty scan
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b1, {27'h0, 1'b0, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_FREE,    32'h0000_5000, 1'b1, {27'h0, 1'b1, 16'd1, 16'd0}});
    dir_tab.push_back('{CMD_RESERVE, 32'h0000_5000, 1'b1, {27'h0, 1'b1, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_RESERVE, 32'h0000_5000, 1'b1, {27'h0, 1'b0, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_FREE,    32'hFFFF_FFFF, 1'b1, {27'h0, 1'b0, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_RELEASE, 32'h0800_0000, 1'b1, {27'h0, 1'b0, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_RESERVE, 32'hFFFF_FFFF, 1'b1, {27'h0, 1'b0, 16'd0, 16'd0}});
    dir_tab.push_back('{CMD_RELEASE, 32'h0000_0FFF, 1'b1, {27'h0, 1'b1, 16'd1, 16'd1}});
    dir_tab.push_back('{CMD_FREE,    32'h0000_0000, 1'b1, {27'h0, 1'b0, 16'd1, 16'd1}});
    dir_tab.push_back('{CMD_ALLOC,   32'hFFFF_FFFF, 1'b1, {27'h0, 1'b1, 16'd0, 16'd1}});
    dir_tab.push_back('{CMD_RELEASE, 32'h07FF_FFFF, 1'b1, {27'h0, 1'b1, 16'd1, 16'd2}});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b1,
                        {27'h7FF_F000, 1'b1, 16'd0, 16'd2}});
    dir_tab.push_back('{CMD_RELEASE, 32'h0000_3ABC, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RELEASE, 32'h0000_3001, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_FREE,    32'h07FF_F000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RESERVE, 32'h07FF_F123, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RELEASE, 32'h0001_F000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RELEASE, 32'h0002_0FFF, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_FREE,    32'h8000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    foreach (dir_tab[i]) begin
      r.cmd          = dir_tab[i].cmd;
      r.phys_address = dir_tab[i].addr;
      issue(r, dir_tab[i].typed, dir_tab[i].want);
    end

    // random part in phases of sender idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      send_idle = (p == 1 || p == 3) ? 63 : (p == 2 ? 9 : 0);
      for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
        sel   = $urandom_range(99);
        r.cmd = sel < 30 ? CMD_ALLOC : sel < 55 ? CMD_FREE :
                sel < 80 ? CMD_RELEASE : CMD_RESERVE;
        r.phys_address = pick_address();
        issue(r, 1'b0, NO_RES);
      end
    end

    // a few more requests on frames in the range the random part draws from
    send_idle = 9;
    dir_tab.delete();
    dir_tab.push_back('{CMD_FREE,    32'h003E_8000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RELEASE, 32'h000C_8000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_RESERVE, 32'h000C_8000, 1'b0, NO_RES});
    dir_tab.push_back('{CMD_ALLOC,   32'h0000_0000, 1'b0, NO_RES});
    foreach (dir_tab[i]) begin
      r.cmd          = dir_tab[i].cmd;
      r.phys_address = dir_tab[i].addr;
      issue(r, dir_tab[i].typed, dir_tab[i].want);
    end
    start <= 1'b0;

    // drain, then a short tail for stray strobes
    while (awaited_res.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
